// File: sv/knas_pkg.sv
// Shared sizes, register indexes and widths for the novelty archive scorer.
// Used by every module of the block but knas_ram; depends on nothing.
package knas_pkg;
    localparam int ARCHIVE_DEPTH  = 256;
    localparam int VECTOR_LEN     = 20;
    localparam int MAX_NEIGHBOURS = 16;

    localparam int MEM_DEPTH = ARCHIVE_DEPTH * VECTOR_LEN;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int FILL_W    = $clog2(ARCHIVE_DEPTH + 1);
    localparam int IDX_W     = (VECTOR_LEN > 1) ? $clog2(VECTOR_LEN) : 1;
    localparam int POS_W     = $clog2(VECTOR_LEN + 1);
    localparam int NB_W      = $clog2(MAX_NEIGHBOURS + 1);
    localparam int NBI_W     = (MAX_NEIGHBOURS > 1) ? $clog2(MAX_NEIGHBOURS) : 1;

    localparam int ELEM_W = 16;
    localparam int SQD_W  = 2 * (ELEM_W + 1);
    localparam int SQ_W   = 40;
    localparam int DIST_W = 20;
    localparam int SUM_W  = DIST_W + NB_W;

    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 20;
    localparam int NBC_W      = 5;

    localparam logic [CFG_ADDR_W-1:0] REG_THRESHOLD  = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_NEIGHBOURS = 1'd1;

    localparam logic [DIST_W-1:0] DIST_ONES = '1;
endpackage

// File: sv/knas_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Stands alone; holds the archived vectors.
module knas_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: sv/knas_isqrt.sv
// Iterative floor square root, one result bit per cycle.
// Depends on knas_pkg for the operand and root widths.
module knas_isqrt (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [knas_pkg::SQ_W-1:0]  i_value,
    output logic                       o_done,
    output logic [knas_pkg::DIST_W-1:0] o_root
);
    import knas_pkg::*;

    localparam int CNT_W = $clog2(DIST_W + 1);

    logic [SQ_W-1:0]     r_val;
    logic [DIST_W+1:0]   r_rem;
    logic [DIST_W-1:0]   r_root;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_busy;
    logic                r_done;
    logic [DIST_W+3:0]   n_rem;
    logic [DIST_W+3:0]   n_trial;

    always_comb begin
        n_rem   = {r_rem, r_val[SQ_W-1 -: 2]};
        n_trial = {2'b00, r_root, 2'b01};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_val  <= i_value;
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_val <= {r_val[SQ_W-3:0], 2'b00};
                if (n_rem >= n_trial) begin
                    r_rem  <= (DIST_W + 2)'(n_rem - n_trial);
                    r_root <= {r_root[DIST_W-2:0], 1'b1};
                end else begin
                    r_rem  <= (DIST_W + 2)'(n_rem);
                    r_root <= {r_root[DIST_W-2:0], 1'b0};
                end
                if (r_cnt == CNT_W'(DIST_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + CNT_W'(1);
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule

// File: sv/knas_divider.sv
// Restoring divider for the neighbour mean, one quotient bit per cycle.
// Depends on knas_pkg for the sum and count widths.
module knas_divider (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [knas_pkg::SUM_W-1:0] i_dividend,
    input  logic [knas_pkg::NB_W-1:0]  i_divisor,
    output logic                       o_done,
    output logic [knas_pkg::SUM_W-1:0] o_quotient
);
    import knas_pkg::*;

    localparam int CNT_W = $clog2(SUM_W + 1);

    logic [SUM_W-1:0] r_quo;
    logic [NB_W:0]    r_rem;
    logic [NB_W-1:0]  r_div;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [NB_W+1:0]  n_rem;

    assign n_rem = {r_rem, r_quo[SUM_W-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_quo  <= i_dividend;
                r_div  <= i_divisor;
                r_rem  <= '0;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (n_rem >= {2'b00, r_div}) begin
                    r_rem <= (NB_W + 1)'(n_rem - {2'b00, r_div});
                    r_quo <= {r_quo[SUM_W-2:0], 1'b1};
                end else begin
                    r_rem <= (NB_W + 1)'(n_rem);
                    r_quo <= {r_quo[SUM_W-2:0], 1'b0};
                end
                if (r_cnt == CNT_W'(SUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + CNT_W'(1);
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;
endmodule

// File: sv/knn_novelty_archive_scorer_top.sv
// Novelty scorer: collects a behavior vector word by word, scores it against an archive held
// in one RAM, and stores novel vectors. For a final word, every entry is read one coordinate
// per cycle from the RAM read port, then its distance goes through a bit-serial square root,
// and the mean goes through a bit-serial divider. Depends on knas_pkg, knas_ram, knas_isqrt
// and knas_divider.
module knn_novelty_archive_scorer_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [15:0]                      i_s_tdata,  // element_value
    input  logic                             i_s_tuser,  // last_element
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // novelty_score[19:0], was_archived[20], archive_full[21], archive_entries[30:22], zero
    output logic [31:0]                      o_m_tdata,
    input  logic                             i_cfg_we,
    input  logic [knas_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [knas_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);
    import knas_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_STORE, S_SCAN, S_ROOT, S_SUM, S_DIV, S_DECIDE, S_OUT
    } t_state;

    t_state             r_state;
    logic [DIST_W-1:0]  r_threshold;
    logic [NBC_W-1:0]   r_cfg_k;
    logic [ELEM_W-1:0]  r_cur [VECTOR_LEN];
    logic [POS_W-1:0]   r_pos;
    logic [FILL_W-1:0]  r_fill;
    logic [FILL_W-1:0]  r_ent;
    logic [ADDR_W-1:0]  r_rbase;
    logic [ADDR_W-1:0]  r_wbase;
    logic [POS_W-1:0]   r_j;
    logic [DIST_W-1:0]  r_near [MAX_NEIGHBOURS];
    logic               r_first;
    logic               r_archived;
    logic               r_full;
    logic               r_v1, r_l1, r_v2, r_l2;
    logic [IDX_W-1:0]   r_jd;
    logic [SQD_W-1:0]   r_sq;
    logic [SQ_W-1:0]    r_acc;
    logic               r_sq_go;
    logic [NBI_W-1:0]   r_s;
    logic [SUM_W-1:0]   r_sum;
    logic               r_div_go;
    logic [DIST_W-1:0]  r_novelty;
    logic               r_m_tvalid;
    logic [31:0]        r_m_tdata;

    logic               w_accept;
    logic [POS_W-1:0]   n_pos;
    logic [NB_W-1:0]    w_k;
    logic               w_issue;
    logic               w_ram_we;
    logic [ADDR_W-1:0]  w_raddr;
    logic [ADDR_W-1:0]  w_waddr;
    logic [ELEM_W-1:0]  w_rdata;
    logic signed [ELEM_W:0] w_diff;
    logic signed [SQD_W-1:0] w_sq;
    logic               w_root_done;
    logic [DIST_W-1:0]  w_root;
    logic               w_div_done;
    logic [SUM_W-1:0]   w_quo;
    logic [DIST_W-1:0]  n_near [MAX_NEIGHBOURS];

    assign w_accept = i_s_tvalid && (r_state == S_IDLE);
    assign n_pos    = (int'(r_pos) < VECTOR_LEN) ? r_pos + POS_W'(1) : r_pos;
    assign w_issue  = (r_state == S_SCAN) && (int'(r_j) < VECTOR_LEN);
    assign w_ram_we = (r_state == S_STORE);
    assign w_raddr  = r_rbase + ADDR_W'(r_j);
    assign w_waddr  = r_wbase + ADDR_W'(r_j);
    assign w_diff   = $signed({r_cur[r_jd][ELEM_W-1], r_cur[r_jd]})
                    - $signed({w_rdata[ELEM_W-1], w_rdata});
    assign w_sq     = w_diff * w_diff;

    // Effective k: zero counts as one, large values saturate, and never above the fill.
    always_comb begin
        if (r_cfg_k == '0) begin
            w_k = NB_W'(1);
        end else if (int'(r_cfg_k) > MAX_NEIGHBOURS) begin
            w_k = NB_W'(MAX_NEIGHBOURS);
        end else begin
            w_k = NB_W'(r_cfg_k);
        end
        if (int'(r_fill) < int'(w_k)) begin
            w_k = NB_W'(r_fill);
        end
    end

    // Sorted insert of the new distance into the first k places of the nearest list.
    always_comb begin
        for (int p = 0; p < MAX_NEIGHBOURS; p++) begin
            n_near[p] = r_near[p];
            if (p < int'(w_k) && r_near[p] > w_root) begin
                if (p == 0) begin
                    n_near[p] = w_root;
                end else if (r_near[p-1] <= w_root) begin
                    n_near[p] = w_root;
                end else begin
                    n_near[p] = r_near[p-1];
                end
            end
        end
    end

    knas_ram #(.WIDTH(ELEM_W), .DEPTH(MEM_DEPTH)) u_archive (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_waddr),
        .i_wdata (r_cur[r_j[IDX_W-1:0]]),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    knas_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_sq_go),
        .i_value (r_acc),
        .o_done  (w_root_done),
        .o_root  (w_root)
    );

    knas_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_go),
        .i_dividend (r_sum),
        .i_divisor  (w_k),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_threshold <= '0;
            r_cfg_k     <= NBC_W'(15);
            r_pos       <= '0;
            r_fill      <= '0;
            r_wbase     <= '0;
            r_v1        <= 1'b0;
            r_l1        <= 1'b0;
            r_v2        <= 1'b0;
            r_l2        <= 1'b0;
            r_sq_go     <= 1'b0;
            r_div_go    <= 1'b0;
            r_m_tvalid  <= 1'b0;
        end else begin
            r_sq_go  <= (r_state == S_SCAN) && r_l2;
            r_div_go <= (r_state == S_SUM) && (int'(r_s) == MAX_NEIGHBOURS - 1);

            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_THRESHOLD:  r_threshold <= i_cfg_wdata[DIST_W-1:0];
                    REG_NEIGHBOURS: r_cfg_k     <= i_cfg_wdata[NBC_W-1:0];
                    default: ;
                endcase
            end

            if (r_m_tvalid && i_m_tready && r_state != S_OUT) begin
                r_m_tvalid <= 1'b0;
            end

            // Read pipeline: address, then RAM data and difference, then accumulate.
            r_v1 <= w_issue;
            r_l1 <= w_issue && (int'(r_j) == VECTOR_LEN - 1);
            r_jd <= r_j[IDX_W-1:0];
            r_v2 <= r_v1;
            r_l2 <= r_l1;
            r_sq <= $unsigned(w_sq);

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        for (int j = 0; j < VECTOR_LEN; j++) begin
                            if (POS_W'(j) == r_pos) begin
                                r_cur[j] <= i_s_tdata;
                            end else if (i_s_tuser && POS_W'(j) >= n_pos) begin
                                r_cur[j] <= '0;
                            end
                        end
                        r_archived <= 1'b0;
                        r_full     <= 1'b0;
                        r_j        <= '0;
                        r_rbase    <= '0;
                        r_ent      <= '0;
                        r_acc      <= '0;
                        for (int p = 0; p < MAX_NEIGHBOURS; p++) begin
                            r_near[p] <= DIST_ONES;
                        end
                        if (i_s_tuser) begin
                            r_pos   <= '0;
                            r_first <= (r_fill == '0);
                            r_state <= (r_fill == '0) ? S_STORE : S_SCAN;
                        end else begin
                            r_pos <= n_pos;
                        end
                    end
                end
                S_STORE: begin
                    if (int'(r_j) == VECTOR_LEN - 1) begin
                        r_fill     <= r_fill + FILL_W'(1);
                        r_wbase    <= r_wbase + ADDR_W'(VECTOR_LEN);
                        r_archived <= 1'b1;
                        r_j        <= '0;
                        r_state    <= r_first ? S_SCAN : S_OUT;
                    end else begin
                        r_j <= r_j + POS_W'(1);
                    end
                end
                S_SCAN: begin
                    if (w_issue) begin
                        r_j <= r_j + POS_W'(1);
                    end
                    if (r_v2) begin
                        r_acc <= r_acc + SQ_W'(r_sq);
                    end
                    if (r_l2) begin
                        r_state <= S_ROOT;
                    end
                end
                S_ROOT: begin
                    if (w_root_done) begin
                        r_near <= n_near;
                        r_acc  <= '0;
                        r_j    <= '0;
                        if (r_ent + FILL_W'(1) < r_fill) begin
                            r_ent   <= r_ent + FILL_W'(1);
                            r_rbase <= r_rbase + ADDR_W'(VECTOR_LEN);
                            r_state <= S_SCAN;
                        end else begin
                            r_s     <= '0;
                            r_sum   <= '0;
                            r_state <= S_SUM;
                        end
                    end
                end
                S_SUM: begin
                    if (int'(r_s) < int'(w_k)) begin
                        r_sum <= r_sum + SUM_W'(r_near[r_s]);
                    end
                    r_s <= r_s + NBI_W'(1);
                    if (int'(r_s) == MAX_NEIGHBOURS - 1) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_novelty <= w_quo[DIST_W-1:0];
                        r_state   <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    r_first <= 1'b0;
                    r_j     <= '0;
                    if (r_novelty > r_threshold) begin
                        if (int'(r_fill) < ARCHIVE_DEPTH) begin
                            r_state <= S_STORE;
                        end else begin
                            r_full  <= 1'b1;
                            r_state <= S_OUT;
                        end
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_m_tvalid || i_m_tready) begin
                        r_m_tvalid <= 1'b1;
                        r_m_tdata  <= {1'b0, r_fill, r_full, r_archived, r_novelty};
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_fill) <= ARCHIVE_DEPTH)
        else $error("archive fill above depth");
    a_store_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_STORE |-> int'(r_fill) < ARCHIVE_DEPTH)
        else $error("archive write with no free slot");
    a_full_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m_tvalid |-> !(r_m_tdata[20] && r_m_tdata[21]))
        else $error("result both stored and full");
    a_scan_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN |-> r_ent < r_fill)
        else $error("scan past archive fill");
endmodule

// File: dv/tb_knn_novelty_archive_scorer_top.sv
// Self-checking testbench for knn_novelty_archive_scorer_top: streams behavior vectors word by
// word, predicts each novelty result with its own archive model and checks every result word.
// Depends on knas_pkg and the block's RTL.

typedef struct packed {
    logic [19:0] novelty;
    logic        archived;
    logic        full;
    logic [8:0]  entries;
} t_novelty_result;

class novelty_scoreboard;
    logic signed [15:0] archive[knas_pkg::ARCHIVE_DEPTH][knas_pkg::VECTOR_LEN];
    logic signed [15:0] vec[knas_pkg::VECTOR_LEN];
    int                 fill;
    int                 pos;
    logic [19:0]        threshold;
    logic [4:0]         nbr_count;
    t_novelty_result    expected_q[$];
    int                 errors;

    function new();
        fill = 0;
        pos = 0;
        threshold = '0;
        nbr_count = 5'd15;
        errors = 0;
    endfunction

    function void write_reg(logic [knas_pkg::CFG_ADDR_W-1:0] idx,
                            logic [knas_pkg::CFG_DATA_W-1:0] val);
        if (idx == knas_pkg::REG_THRESHOLD)
            threshold = val[19:0];
        else if (idx == knas_pkg::REG_NEIGHBOURS)
            nbr_count = val[4:0];
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function void store_vector();
        if (fill < knas_pkg::ARCHIVE_DEPTH) begin
            for (int j = 0; j < knas_pkg::VECTOR_LEN; j++)
                archive[fill][j] = vec[j];
            fill++;
        end
    endfunction

    // Called for every accepted input word; a closing word queues one result.
    function void note_word(logic signed [15:0] x, logic last);
        t_novelty_result r;
        int              k;
        longint unsigned dists[$];
        longint unsigned acc;
        longint signed   diff;
        longint unsigned total;
        if (pos < knas_pkg::VECTOR_LEN) begin
            vec[pos] = x;
            pos++;
        end
        if (!last)
            return;
        for (int j = pos; j < knas_pkg::VECTOR_LEN; j++)
            vec[j] = '0;
        pos = 0;
        r = '0;
        if (fill == 0) begin
            store_vector();
            r.archived = 1'b1;
        end
        k = (nbr_count == 0) ? 1 : nbr_count;
        if (k > knas_pkg::MAX_NEIGHBOURS)
            k = knas_pkg::MAX_NEIGHBOURS;
        if (k > fill)
            k = fill;
        for (int i = 0; i < fill; i++) begin
            acc = 0;
            for (int j = 0; j < knas_pkg::VECTOR_LEN; j++) begin
                diff = longint'(vec[j]) - longint'(archive[i][j]);
                acc += longint'(diff * diff);
            end
            dists = {dists, int_sqrt(acc & 64'hFF_FFFF_FFFF)};
        end
        dists.sort();
        total = 0;
        for (int i = 0; i < k; i++)
            total += dists[i];
        r.novelty = (k != 0) ? 20'(total / k) : 20'd0;
        if (r.novelty > threshold) begin
            if (fill < knas_pkg::ARCHIVE_DEPTH) begin
                store_vector();
                r.archived = 1'b1;
            end else begin
                r.full = 1'b1;
            end
        end
        r.entries = 9'(fill);
        expected_q = {expected_q, r};
    endfunction

    function void check_result(logic [31:0] data);
        t_novelty_result e;
        if (expected_q.size() == 0) begin
            $display("%0t: unexpected result word %h", $time, data);
            errors++;
            return;
        end
        e = expected_q.pop_front();
        if (data[19:0] != e.novelty) begin
            $display("%0t: novelty_score expected %0d actual %0d", $time, e.novelty,
                     data[19:0]);
            errors++;
        end
        if (data[20] != e.archived) begin
            $display("%0t: was_archived expected %0d actual %0d", $time, e.archived, data[20]);
            errors++;
        end
        if (data[21] != e.full) begin
            $display("%0t: archive_full expected %0d actual %0d", $time, e.full, data[21]);
            errors++;
        end
        if (data[30:22] != e.entries) begin
            $display("%0t: archive_entries expected %0d actual %0d", $time, e.entries,
                     data[30:22]);
            errors++;
        end
    endfunction
endclass

module tb_knn_novelty_archive_scorer_top;
    timeunit 1ns;
    timeprecision 1ps;
    import knas_pkg::*;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [15:0]           i_s_tdata;
    logic                  i_s_tuser;
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    logic [31:0]           o_m_tdata;
    logic                  i_cfg_we;
    logic [CFG_ADDR_W-1:0] i_cfg_addr;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    novelty_scoreboard sb;
    int                burst_left;
    bit                long_hold;

    knn_novelty_archive_scorer_top dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #400ms;
        $display("TEST FAILED");
        $finish;
    end

    // Result monitor: a word is taken at the edge after a negedge that saw valid and ready.
    always @(negedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            sb.check_result(o_m_tdata);
    end

    // Receiver backpressure: picks a new stall pattern at random during alternate time windows,
    // keeps the last one through the windows between, and holds off for a long stretch when asked to.
    initial begin : rx_stall
        int mode;
        int hold;
        i_m_tready = 1'b0;
        mode = 0;
        forever begin
            @(posedge i_clk);
            if (long_hold) begin
                i_m_tready <= 1'b0;
                for (hold = 0; hold < 4000; hold++)
                    @(posedge i_clk);
                long_hold = 1'b0;
            end
            if (($time / 640) % 2 == 0)
                mode = $urandom_range(2, 0);
            case (mode)
                0: i_m_tready <= 1'b1;
                1: i_m_tready <= $urandom_range(1, 0);
                default: i_m_tready <= ($urandom_range(7, 0) == 0);
            endcase
        end
    end

    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        sb.write_reg(idx, val);
        i_cfg_we    <= 1'b0;
    endtask

    // Drops the input valid, waits until every queued result has arrived, then lets any
    // trailing work drain.
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic send_word(logic [15:0] x, logic last);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(8, 0);
            if (gap != 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(12, 1);
        end
        burst_left--;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= x;
        i_s_tuser  <= last;
        @(negedge i_clk);
        while (!o_s_tready)
            @(negedge i_clk);
        @(posedge i_clk);
        sb.note_word(x, last);
    endtask

    task automatic send_vector(int len, bit near_values);
        logic [15:0] x;
        for (int i = 0; i < len; i++) begin
            x = near_values ? 16'($signed($urandom_range(400, 0)) - 200) : 16'($urandom);
            send_word(x, i == len - 1);
        end
    endtask

    initial begin : main
        int words;
        int len;
        int seg;
        sb = new();
        burst_left = 0;
        long_hold = 1'b0;
        i_rst_n     <= 1'b0;
        i_s_tvalid  <= 1'b0;
        i_s_tdata   <= '0;
        i_s_tuser   <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_addr  <= '0;
        i_cfg_wdata <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty archive stores first, extremes, short and long vectors.
        send_word(16'h7FFF, 1'b0);
        send_word(16'h8000, 1'b1);
        send_word(16'h8000, 1'b1);
        for (int i = 0; i <= VECTOR_LEN; i++)
            send_word((i % 2) ? 16'h7FFF : 16'h8000, i == VECTOR_LEN);
        wait_drained();
        // Neighbour count of zero acts as one; above the maximum it saturates.
        write_reg(REG_NEIGHBOURS, 20'd0);
        write_reg(REG_THRESHOLD, 20'hFFFFF);
        send_word(16'h0001, 1'b1);
        wait_drained();
        write_reg(REG_NEIGHBOURS, 20'hFFFFF);
        write_reg(REG_THRESHOLD, 20'd0);
        send_word(16'hFFFF, 1'b1);
        wait_drained();
        write_reg(REG_NEIGHBOURS, 20'd16);
        send_word(16'h0000, 1'b1);

        // Random segments; the threshold is kept high once the archive grows, so scoring
        // stays quick until the final fill.
        words = 0;
        seg = 0;
        while (words < 1000) begin
            wait_drained();
            if (sb.fill >= 48)
                write_reg(REG_THRESHOLD, 20'hFFFFF);
            else
                case ($urandom_range(3, 0))
                    0: write_reg(REG_THRESHOLD, 20'd0);
                    1: write_reg(REG_THRESHOLD, 20'($urandom_range(4000, 0)));
                    2: write_reg(REG_THRESHOLD, 20'($urandom));
                    default: write_reg(REG_THRESHOLD, 20'hFFFFF);
                endcase
            write_reg(REG_NEIGHBOURS, 20'($urandom));
            if (seg == 3)
                long_hold = 1'b1;
            for (int n = 0; n < 100; ) begin
                case ($urandom_range(9, 0))
                    0, 1: len = $urandom_range(3, 1);
                    2:    len = $urandom_range(VECTOR_LEN + 6, VECTOR_LEN + 1);
                    default: len = $urandom_range(VECTOR_LEN, 1);
                endcase
                send_vector(len, $urandom_range(1, 0));
                n += len;
                words += len;
            end
            seg++;
        end

        // Fill the archive to the top, then show that further novel vectors are refused.
        wait_drained();
        write_reg(REG_THRESHOLD, 20'd0);
        write_reg(REG_NEIGHBOURS, 20'($urandom_range(16, 1)));
        len = 0;
        while (sb.fill < ARCHIVE_DEPTH || len < 6) begin
            if (sb.fill >= ARCHIVE_DEPTH)
                len++;
            send_vector(1, 1'b0);
        end

        wait_drained();
        repeat (200) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
